FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the AES-128 core files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

FILE: rtl/core/aes_pkg.sv
// Package with AES-128 constants, types and byte-level functions.
package aes_pkg;
  localparam int unsigned Rounds = 10;
  localparam int unsigned KeyWords = 4 * (Rounds + 1);
  localparam int unsigned KeyAddrW = $clog2(KeyWords);
  localparam int unsigned RoundW = $clog2(Rounds + 1);

  localparam logic [0:0] ActEncrypt = 1'b0;
  localparam logic [0:0] ActDecrypt = 1'b1;

  localparam logic [0:0] RegKeyHigh = 1'b0;
  localparam logic [0:0] RegKeyLow = 1'b1;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] block_t;

  typedef struct packed {
    logic                req;
    logic [KeyAddrW-1:0] addr;
  } key_rd_t;

  function automatic byte_t sbox(input byte_t a);
    byte_t r;
    unique case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; 8'hff: r=8'h16;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic byte_t sbox_rev(input byte_t a);
    byte_t r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (sbox(byte_t'(i)) == a) begin
        r = byte_t'(i);
      end
    end
    return r;
  endfunction

  function automatic byte_t xt(input byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic byte_t gb(input block_t s, input int unsigned i);
    return s[127-8*i -: 8];
  endfunction

  function automatic block_t sub_shift(input block_t s, input logic inv);
    block_t r;
    byte_t b;
    int unsigned src;
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int w = 0; w < 4; w++) begin
        src = inv ? 4 * ((c + 3 * w) % 4) + w : 4 * ((c + w) % 4) + w;
        b = gb(s, src);
        r[127-8*(4*c+w) -: 8] = inv ? sbox_rev(b) : sbox(b);
      end
    end
    return r;
  endfunction

  function automatic block_t mix(input block_t s, input logic inv);
    block_t r;
    byte_t a0, a1, a2, a3, x2, x4, x8, v;
    byte_t col [4];
    r = '0;
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        col[k] = gb(s, 4 * c + k);
      end
      for (int w = 0; w < 4; w++) begin
        a0 = col[w]; a1 = col[(w+1)%4]; a2 = col[(w+2)%4]; a3 = col[(w+3)%4];
        if (!inv) begin
          v = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
        end else begin
          v = 8'h00;
          for (int k = 0; k < 4; k++) begin
            x2 = xt(col[(w+k)%4]); x4 = xt(x2); x8 = xt(x4);
            unique case (k)
              0: v = v ^ x8 ^ x4 ^ x2;
              1: v = v ^ x8 ^ x2 ^ col[(w+k)%4];
              2: v = v ^ x8 ^ x4 ^ col[(w+k)%4];
              default: v = v ^ x8 ^ col[(w+k)%4];
            endcase
          end
        end
        r[127-8*(4*c+w) -: 8] = v;
      end
    end
    return r;
  endfunction
endpackage

FILE: rtl/core/aes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module aes_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 44
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

FILE: rtl/core/aes_keyexp.sv
// Key expansion engine that writes the round key words into the key RAM.
module aes_keyexp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [127:0]                key_i,
  output logic                        busy_o,
  output logic                        we_o,
  output logic [aes_pkg::KeyAddrW-1:0] waddr_o,
  output logic [31:0]                 wdata_o
);
  import aes_pkg::*;

  logic                busy_q, busy_d;
  logic [KeyAddrW-1:0] idx_q, idx_d;
  logic [31:0]         w_q [4];
  logic [31:0]         w_d [4];
  logic [7:0]          rc_q, rc_d;
  logic [31:0]         t, rot, nw;

  always_comb begin
    rot = {w_q[3][23:0], w_q[3][31:24]};
    t = w_q[3];
    if (idx_q[1:0] == 2'd0) begin
      t = {sbox(rot[31:24]) ^ rc_q, sbox(rot[23:16]), sbox(rot[15:8]), sbox(rot[7:0])};
    end
    nw = w_q[0] ^ t;
    busy_d = busy_q;
    idx_d = idx_q;
    rc_d = rc_q;
    w_d = w_q;
    we_o = 1'b0;
    waddr_o = idx_q;
    wdata_o = nw;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      idx_d = KeyAddrW'(0);
      rc_d = 8'h01;
      w_d[0] = key_i[127:96]; w_d[1] = key_i[95:64];
      w_d[2] = key_i[63:32];  w_d[3] = key_i[31:0];
    end else if (busy_q) begin
      we_o = 1'b1;
      if (idx_q < KeyAddrW'(4)) begin
        wdata_o = w_q[idx_q[1:0]];
      end else begin
        w_d[0] = w_q[1]; w_d[1] = w_q[2]; w_d[2] = w_q[3]; w_d[3] = nw;
        if (idx_q[1:0] == 2'd0) begin
          rc_d = xt(rc_q);
        end
      end
      if (idx_q == KeyAddrW'(KeyWords - 1)) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + KeyAddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    rc_q <= rc_d;
    w_q <= w_d;
  end

  assign busy_o = busy_q;
endmodule

FILE: rtl/core/aes_round.sv
// Shared round datapath with sequencer that reads round keys from the key RAM.
module aes_round (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 inv_i,
  input  aes_pkg::block_t      block_i,
  input  logic [31:0]          rkey_i,
  output aes_pkg::key_rd_t     krd_o,
  output logic                 done_o,
  output aes_pkg::block_t      state_o
);
  import aes_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StRun  = 3'b010,
    StLast = 3'b100
  } st_e;

  st_e                 st_q, st_d;
  logic [RoundW-1:0]   rnd_q, rnd_d;
  logic [1:0]          wrd_q, wrd_d;
  logic                inv_q;
  block_t              s_q, s_d;
  logic [127:0]        kacc_q, kacc_d;
  logic                kv_q;
  logic [RoundW-1:0]   krnd;

  // Each round takes four key word reads; the round unit fires once all four are in.
  always_comb begin
    st_d = st_q;
    rnd_d = rnd_q;
    wrd_d = wrd_q;
    s_d = s_q;
    kacc_d = kacc_q;
    done_o = 1'b0;
    krnd = inv_q ? RoundW'(Rounds) - rnd_q : rnd_q;
    krd_o.req = 1'b0;
    krd_o.addr = KeyAddrW'({krnd, wrd_q});
    if (kv_q) begin
      kacc_d = {kacc_q[95:0], rkey_i};
    end
    unique case (st_q)
      StIdle: begin
        if (start_i) begin
          st_d = StRun;
          rnd_d = '0;
          wrd_d = '0;
          s_d = block_i;
        end
      end
      StRun: begin
        krd_o.req = 1'b1;
        wrd_d = wrd_q + 2'd1;
        if (wrd_q == 2'd3) begin
          st_d = StLast;
        end
      end
      StLast: begin
        if (!kv_q) begin
          if (!inv_q) begin
            if (rnd_q == '0) begin
              s_d = s_q ^ kacc_q;
            end else begin
              s_d = sub_shift(s_q, 1'b0);
              if (rnd_q != RoundW'(Rounds)) begin
                s_d = mix(s_d, 1'b0);
              end
              s_d = s_d ^ kacc_q;
            end
          end else begin
            s_d = s_q ^ kacc_q;
            if (rnd_q != '0 && rnd_q != RoundW'(Rounds)) begin
              s_d = mix(s_d, 1'b1);
            end
            if (rnd_q != RoundW'(Rounds)) begin
              s_d = sub_shift(s_d, 1'b1);
            end
          end
          if (rnd_q == RoundW'(Rounds)) begin
            st_d = StIdle;
            done_o = 1'b1;
          end else begin
            st_d = StRun;
            rnd_d = rnd_q + RoundW'(1);
          end
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      kv_q <= 1'b0;
    end else begin
      st_q <= st_d;
      kv_q <= krd_o.req;
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d;
    wrd_q <= wrd_d;
    s_q <= s_d;
    kacc_q <= kacc_d;
    if (st_q == StIdle && start_i) begin
      inv_q <= inv_i;
    end
  end

  assign state_o = s_q;

  `ASSERT_IMPL(a_done_last, clk_i, rst_ni, done_o, st_q == StLast)
  `ASSERT_NEXT(a_req_run, clk_i, rst_ni, krd_o.req, kv_q)
  `ASSERT_IMPL(a_rnd_range, clk_i, rst_ni, st_q != StIdle, rnd_q <= RoundW'(Rounds))
endmodule

FILE: rtl/core/aes128_block_cipher_top.sv
// Top level of the AES-128 encrypt/decrypt core with valid/ready channels.
// A request runs key expansion, which writes all round key words into the key RAM, then
// 11 rounds, each with four key word reads from the RAM followed by the round computation.
// A new request is taken only once the previous result has been taken at the output.
// The round keys are re-expanded from the key registers before every request.
// Reset clears the key registers to zero and the state machines; the key RAM is not cleared.
module aes128_block_cipher_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        action_i,
  input  logic [63:0] block_high_i,
  input  logic [63:0] block_low_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] result_high_o,
  output logic [63:0] result_low_o
);
  import aes_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    TIdle = 4'b0001,
    TKey  = 4'b0010,
    TRun  = 4'b0100,
    TOut  = 4'b1000
  } top_e;

  top_e                top_q, top_d;
  logic [63:0]         khi_q, klo_q;
  logic                act_q;
  block_t              blk_q;
  logic                kx_start, kx_busy, kx_we;
  logic [KeyAddrW-1:0] kx_addr;
  logic [31:0]         kx_data, rd_data;
  key_rd_t             krd;
  logic                r_start, r_done;
  block_t              r_state;
  logic                kx_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      khi_q <= '0;
      klo_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegKeyHigh: khi_q <= cfg_data_i;
        default:    klo_q <= cfg_data_i;
      endcase
    end
  end

  aes_keyexp u_keyexp (
    .clk_i, .rst_ni, .start_i(kx_start), .key_i({khi_q, klo_q}),
    .busy_o(kx_busy), .we_o(kx_we), .waddr_o(kx_addr), .wdata_o(kx_data)
  );

  aes_ram #(.Width(32), .Depth(KeyWords)) u_key_ram (
    .clk_i, .we_i(kx_we), .waddr_i(kx_addr), .wdata_i(kx_data),
    .re_i(krd.req), .raddr_i(krd.addr), .rdata_o(rd_data)
  );

  aes_round u_round (
    .clk_i, .rst_ni, .start_i(r_start), .inv_i(act_q), .block_i(blk_q),
    .rkey_i(rd_data), .krd_o(krd), .done_o(r_done), .state_o(r_state)
  );

  always_comb begin
    top_d = top_q;
    kx_start = 1'b0;
    r_start = 1'b0;
    unique case (top_q)
      TIdle: if (in_valid_i) begin
        top_d = TKey;
        kx_start = 1'b1;
      end
      TKey: if (kx_busy_q && !kx_busy) begin
        top_d = TRun;
        r_start = 1'b1;
      end
      TRun: if (r_done) begin
        top_d = TOut;
      end
      TOut: if (out_ready_i) begin
        top_d = TIdle;
      end
      default: top_d = TIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= TIdle;
      kx_busy_q <= 1'b0;
    end else begin
      top_q <= top_d;
      kx_busy_q <= kx_busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (top_q == TIdle && in_valid_i) begin
      act_q <= action_i;
      blk_q <= {block_high_i, block_low_i};
    end
  end

  // The round unit sits idle and holds its state while the result waits.
  assign in_ready_o = (top_q == TIdle);
  assign out_valid_o = (top_q == TOut);
  assign result_high_o = r_state[127:64];
  assign result_low_o = r_state[63:0];

  `ASSERT_IMPL(a_ram_excl, clk_i, rst_ni, kx_we, !krd.req)
  `ASSERT_NEXT(a_done_out, clk_i, rst_ni, top_q == TRun && r_done, out_valid_o)
  `ASSERT_IMPL(a_busy_key, clk_i, rst_ni, kx_busy, top_q == TKey)
endmodule
